// File: hdl/hsc_pkg.sv
`timescale 1ns / 1ps

package hsc_pkg;

    localparam int COUNTS_PER_REV_DEF = 24;
    localparam int REV_WIDTH_DEF      = 16;

    localparam int DUTY_W    = 16;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_U    = 2'd1,
        PH_V    = 2'd2,
        PH_W    = 2'd3
    } phase_t;

    typedef enum logic [0:0] {
        CFG_PWM_DUTY     = 1'b0,
        CFG_DRIVE_ENABLE = 1'b1
    } cfg_idx_t;

    // decoded Hall request, registered input side
    typedef struct packed {
        logic       vld;
        logic       fault;
        logic [2:0] sector;
        phase_t     high;
        phase_t     low;
        logic [3:0] angle;
    } hall_item_t;

    typedef struct packed {
        phase_t      high_phase;
        logic [15:0] high_duty;
        phase_t      low_phase;
        logic        turn_direction;
        logic [2:0]  sector_now;
        logic [15:0] revolution_count;
        logic [4:0]  shaft_position;
        logic [3:0]  angle_step;
        logic        hall_fault;
    } hall_result_t;

endpackage

// File: hdl/hall_six_step_commutator.sv
`timescale 1ns / 1ps

// Six-step commutator driven by Hall edges. Each request on the input stream
// carries one 3-bit Hall code and yields exactly one result: drive pattern,
// direction, sector, revolution count, shaft position and electrical angle.
// A request is registered and decoded, then folded into the rotor state as
// the result register is loaded; one request per clock is sustained while
// the output is not stalled. While a result waits on the output, the input
// register takes one more request; others stall until the result is taken.
// Codes 0 and 7 set hall_fault and change nothing. With drive_enable low no
// state moves and no phase is driven. Write pwm_duty and drive_enable only
// while no request is in flight.

module hall_six_step_commutator
    import hsc_pkg::*;
#(
    parameter int COUNTS_PER_REV = COUNTS_PER_REV_DEF,
    parameter int REV_WIDTH      = REV_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_addr,
    input  logic [DUTY_W-1:0]     cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [2:0] hall_bits, [7:3] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] high_phase, [17:2] high_duty, [19:18] low_phase,
    // [20] turn_direction, [23:21] sector_now, [39:24] revolution_count,
    // [44:40] shaft_position, [48:45] angle_step, [49] hall_fault, [55:50] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [DUTY_W-1:0] duty_reg;
    logic              enable_reg;
    logic              advance;
    hall_item_t        item;
    hall_result_t      result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg   <= '0;
            enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_PWM_DUTY:     duty_reg   <= cfg_wdata;
                CFG_DRIVE_ENABLE: enable_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    hsc_input_stage u_input (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .item          (item)
    );

    hsc_tracker #(
        .COUNTS_PER_REV (COUNTS_PER_REV),
        .REV_WIDTH      (REV_WIDTH)
    ) u_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .pwm_duty      (duty_reg),
        .drive_enable  (enable_reg),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .advance       (advance),
        .result        (result)
    );

    assign m_axis_tdata = {
        6'd0,
        result.hall_fault,
        result.angle_step,
        result.shaft_position,
        result.revolution_count,
        result.sector_now,
        result.turn_direction,
        result.low_phase,
        result.high_duty,
        result.high_phase
    };

endmodule

// File: hdl/hsc_input_stage.sv
`timescale 1ns / 1ps

module hsc_input_stage
    import hsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic                 advance,
    output hall_item_t           item
);

    logic       in_vld_reg;
    logic [2:0] hall_reg;

    assign s_axis_tready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            hall_reg <= s_axis_tdata[2:0];
        end
    end

    // Hall code -> sector, six-step pattern, angle and fault flag
    always_comb
    begin
        item.vld    = in_vld_reg;
        item.fault  = 1'b0;
        item.sector = 3'd0;
        item.high   = PH_NONE;
        item.low    = PH_NONE;
        item.angle  = 4'd0;
        case (hall_reg)
            3'd1:
            begin
                item.sector = 3'd0; item.high = PH_U; item.low = PH_W; item.angle = 4'd11;
            end
            3'd2:
            begin
                item.sector = 3'd4; item.high = PH_V; item.low = PH_U; item.angle = 4'd3;
            end
            3'd3:
            begin
                item.sector = 3'd5; item.high = PH_V; item.low = PH_W; item.angle = 4'd1;
            end
            3'd4:
            begin
                item.sector = 3'd2; item.high = PH_W; item.low = PH_V; item.angle = 4'd7;
            end
            3'd5:
            begin
                item.sector = 3'd1; item.high = PH_U; item.low = PH_V; item.angle = 4'd9;
            end
            3'd6:
            begin
                item.sector = 3'd3; item.high = PH_W; item.low = PH_U; item.angle = 4'd5;
            end
            default:
            begin
                item.fault = 1'b1;
            end
        endcase
    end

endmodule

// File: hdl/hsc_tracker.sv
`timescale 1ns / 1ps

module hsc_tracker
    import hsc_pkg::*;
#(
    parameter int COUNTS_PER_REV = COUNTS_PER_REV_DEF,
    parameter int REV_WIDTH      = REV_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  hall_item_t        item,
    input  logic [DUTY_W-1:0] pwm_duty,
    input  logic              drive_enable,
    input  logic              m_axis_tready,
    output logic              m_axis_tvalid,
    output logic              advance,
    output hall_result_t      result
);

    localparam int POS_W = $clog2(COUNTS_PER_REV);
    localparam int PW    = POS_W + 2;
    // position jump when the signed revolution count wraps
    localparam longint unsigned WRAP_ADJ =
        ((64'd6) << REV_WIDTH) % 64'(COUNTS_PER_REV);
    localparam logic signed [PW-1:0] CPR_S = PW'(COUNTS_PER_REV);
    localparam logic signed [PW-1:0] ADJ_S = PW'(WRAP_ADJ);
    localparam logic [REV_WIDTH-1:0] REV_MAX = {1'b0, {(REV_WIDTH-1){1'b1}}};
    localparam logic [REV_WIDTH-1:0] REV_MIN = {1'b1, {(REV_WIDTH-1){1'b0}}};

    logic [2:0]           sector_reg, sector_next;
    logic [REV_WIDTH-1:0] rev_reg, rev_next;
    logic                 dir_reg, dir_next;
    phase_t               high_reg, high_next;
    phase_t               low_reg, low_next;
    logic [3:0]           angle_reg, angle_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 out_vld_reg;
    hall_result_t         res_reg, res_next;

    logic                 step_en;
    logic                 upd;
    logic signed [3:0]    diff;
    logic signed [3:0]    step;
    logic                 wrap_fwd;
    logic                 wrap_bwd;
    logic signed [PW-1:0] p0, p1, p2;
    logic [REV_WIDTH+15:0] rev_ext;
    logic [POS_W+4:0]     pos_ext;

    assign advance       = !out_vld_reg || m_axis_tready;
    assign step_en       = item.vld && advance;
    assign upd           = step_en && drive_enable && !item.fault;
    assign m_axis_tvalid = out_vld_reg;
    assign result        = res_reg;

    assign diff     = $signed({1'b0, item.sector}) - $signed({1'b0, sector_reg});
    assign wrap_fwd = diff < -4'sd3;
    assign wrap_bwd = diff > 4'sd3;

    always_comb
    begin
        if (wrap_fwd)
            step = diff + 4'sd6;
        else if (wrap_bwd)
            step = diff - 4'sd6;
        else
            step = diff;

        p0 = $signed({2'b00, pos_reg}) + PW'(step);
        if (p0 < 0)
            p1 = p0 + CPR_S;
        else if (p0 >= CPR_S)
            p1 = p0 - CPR_S;
        else
            p1 = p0;

        p2 = p1;
        if (wrap_fwd && (rev_reg == REV_MAX))
        begin
            p2 = p1 - ADJ_S;
            if (p2 < 0)
                p2 = p2 + CPR_S;
        end
        else if (wrap_bwd && (rev_reg == REV_MIN))
        begin
            p2 = p1 + ADJ_S;
            if (p2 >= CPR_S)
                p2 = p2 - CPR_S;
        end
    end

    always_comb
    begin
        sector_next = sector_reg;
        rev_next    = rev_reg;
        dir_next    = dir_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        angle_next  = angle_reg;
        pos_next    = pos_reg;
        if (upd)
        begin
            sector_next = item.sector;
            high_next   = item.high;
            low_next    = item.low;
            angle_next  = item.angle;
            pos_next    = p2[POS_W-1:0];
            if (wrap_bwd)
            begin
                dir_next = 1'b1;
                rev_next = rev_reg - REV_WIDTH'(1);
            end
            else if (wrap_fwd)
            begin
                dir_next = 1'b0;
                rev_next = rev_reg + REV_WIDTH'(1);
            end
            else if (diff > 0)
                dir_next = 1'b0;
            else if (diff < 0)
                dir_next = 1'b1;
        end
    end

    assign rev_ext = {16'd0, rev_next};
    assign pos_ext = {5'd0, pos_next};

    always_comb
    begin
        if (drive_enable && (high_next != PH_NONE))
        begin
            res_next.high_phase = high_next;
            res_next.high_duty  = pwm_duty;
            res_next.low_phase  = low_next;
        end
        else
        begin
            res_next.high_phase = PH_NONE;
            res_next.high_duty  = '0;
            res_next.low_phase  = PH_NONE;
        end
        res_next.turn_direction   = dir_next;
        res_next.sector_now       = sector_next;
        res_next.revolution_count = rev_ext[15:0];
        res_next.shaft_position   = pos_ext[4:0];
        res_next.angle_step       = angle_next;
        res_next.hall_fault       = item.fault;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_reg  <= '0;
            rev_reg     <= '0;
            dir_reg     <= 1'b0;
            high_reg    <= PH_NONE;
            low_reg     <= PH_NONE;
            angle_reg   <= '0;
            pos_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            sector_reg <= sector_next;
            rev_reg    <= rev_next;
            dir_reg    <= dir_next;
            high_reg   <= high_next;
            low_reg    <= low_next;
            angle_reg  <= angle_next;
            pos_reg    <= pos_next;
            if (advance)
                out_vld_reg <= item.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            res_reg <= res_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pos_reg} < (POS_W+1)'(COUNTS_PER_REV))
        else $error("shaft position out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && (!drive_enable || item.fault)) |=>
            ($stable(rev_reg) && $stable(sector_reg) && $stable(pos_reg)))
        else $error("state moved on a disabled or faulted request");

    // a wrap always lands in sectors 0, 1 (forward) or 4, 5 (backward)
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(rev_reg) |-> ((sector_reg != 3'd2) && (sector_reg != 3'd3)))
        else $error("revolution count changed away from the 5/0 boundary");

endmodule
